// ===== hdl/pba_pkg.sv =====
// Shared types, codes and alignment helper for the paged bump allocator.
`timescale 1ns / 1ps

package pba_pkg;

  // Field widths fixed by the transaction format
  localparam int unsigned SizeW   = 25;
  localparam int unsigned AlignW  = 5;
  localparam int unsigned IndexW  = 4;
  localparam int unsigned StatusW = 3;

  // Largest exponent whose alignment still fits a 25-bit value
  localparam logic [AlignW-1:0] MaxAlignLog2 = 5'd24;

  // Defaults
  localparam int unsigned       DefMaxPages  = 16;
  localparam logic [SizeW-1:0]  DefPageBytes = 25'd65536;

  // Operation codes
  localparam logic OpAlloc = 1'b0;
  localparam logic OpReset = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_TOO_BIG  = 3'd1,
    ST_EXHAUST  = 3'd2,
    ST_NO_FIT   = 3'd3,
    ST_RESET    = 3'd4
  } pba_status_e;

  typedef struct packed {
    logic              op;
    logic [SizeW-1:0]  size_bytes;
    logic [AlignW-1:0] align_log2;
  } pba_item_t;

  typedef struct packed {
    pba_status_e        status;
    logic [IndexW-1:0]  page_index;
    logic [SizeW-1:0]   page_offset;
    logic               took_page;
  } pba_result_t;

  // Round v up to a multiple of 2**lg. Any exponent past 24 on a nonzero value saturates
  // to 2**25, which is above every legal page size and so never fits.
  function automatic logic [SizeW:0] align_up(input logic [SizeW-1:0]  v,
                                              input logic [AlignW-1:0] lg);
    logic [SizeW:0] mask;
    logic [SizeW:0] sum;
    mask = ((SizeW+1)'(1) << lg) - (SizeW+1)'(1);
    sum  = {1'b0, v} + mask;
    if (lg > MaxAlignLog2) begin
      align_up = (v == '0) ? '0 : {1'b1, {SizeW{1'b0}}};
    end else begin
      align_up = sum & ~mask;
    end
  endfunction

endpackage

// ===== hdl/pba_alloc_core.sv =====
// Allocator state and the combinational placement decision for one transaction.
`timescale 1ns / 1ps

module pba_alloc_core #(
  parameter int unsigned MaxPages = pba_pkg::DefMaxPages,
  localparam int unsigned PW = $clog2(MaxPages + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  pba_pkg::pba_item_t          item_i,
  input  logic [pba_pkg::SizeW-1:0]   page_bytes_i,
  output pba_pkg::pba_result_t        result_o,
  output logic [PW-1:0]               pages_created_o,
  output logic [PW-1:0]               next_avail_o
);

  localparam int unsigned SW = pba_pkg::SizeW;

  // Pool and fill state
  logic          cur_valid_q, cur_valid_d;
  logic [PW-1:0] cur_page_q,  cur_page_d;
  logic [SW-1:0] fill_q,      fill_d;
  logic [PW-1:0] created_q,   created_d;
  logic [PW-1:0] next_q,      next_d;

  // Datapath
  logic [SW:0]   asize;
  logic [SW:0]   aoff;
  logic [SW+1:0] end_cur;
  logic          fit_cur;
  logic          fit_fresh;
  logic          need_page;
  logic          have_avail;
  logic          can_create;
  logic [PW-1:0] new_page;
  logic [PW+pba_pkg::IndexW-1:0] idx_wide;

  // Alignment and fit tests against the current page and a fresh page
  assign asize     = pba_pkg::align_up(item_i.size_bytes, item_i.align_log2);
  assign aoff      = pba_pkg::align_up(fill_q, item_i.align_log2);
  assign end_cur   = {1'b0, aoff} + {1'b0, asize};
  assign fit_cur   = end_cur <= {2'b00, page_bytes_i};
  assign fit_fresh = asize <= {1'b0, page_bytes_i};

  assign need_page  = !cur_valid_q || !fit_cur;
  assign have_avail = next_q < created_q;
  assign can_create = created_q < PW'(MaxPages);
  assign new_page   = have_avail ? next_q : created_q;

  // Placement decision
  always_comb begin
    cur_valid_d = cur_valid_q;
    cur_page_d  = cur_page_q;
    fill_d      = fill_q;
    created_d   = created_q;
    next_d      = next_q;
    result_o    = '0;
    idx_wide    = '0;

    if (item_i.op == pba_pkg::OpReset) begin
      cur_valid_d     = 1'b0;
      fill_d          = '0;
      next_d          = '0;
      result_o.status = pba_pkg::ST_RESET;
    end else if (item_i.size_bytes > page_bytes_i) begin
      result_o.status = pba_pkg::ST_TOO_BIG;
    end else if (need_page && !have_avail && !can_create) begin
      result_o.status = pba_pkg::ST_EXHAUST;
    end else if (need_page) begin
      // Switch to a reused or a freshly created page
      cur_valid_d        = 1'b1;
      cur_page_d         = new_page;
      if (have_avail) begin
        next_d = next_q + PW'(1);
      end else begin
        created_d = created_q + PW'(1);
        next_d    = created_q + PW'(1);
      end
      idx_wide           = {{pba_pkg::IndexW{1'b0}}, new_page};
      result_o.took_page = 1'b1;
      result_o.page_index = idx_wide[pba_pkg::IndexW-1:0];
      if (fit_fresh) begin
        result_o.status = pba_pkg::ST_OK;
        fill_d          = asize[SW-1:0];
      end else begin
        result_o.status = pba_pkg::ST_NO_FIT;
        fill_d          = '0;
      end
    end else begin
      // Fits behind the current fill point
      idx_wide             = {{pba_pkg::IndexW{1'b0}}, cur_page_q};
      result_o.status      = pba_pkg::ST_OK;
      result_o.page_index  = idx_wide[pba_pkg::IndexW-1:0];
      result_o.page_offset = aoff[SW-1:0];
      fill_d               = end_cur[SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      cur_page_q  <= '0;
      fill_q      <= '0;
      created_q   <= '0;
      next_q      <= '0;
    end else if (fire_i) begin
      cur_valid_q <= cur_valid_d;
      cur_page_q  <= cur_page_d;
      fill_q      <= fill_d;
      created_q   <= created_d;
      next_q      <= next_d;
    end
  end

  assign pages_created_o = created_q;
  assign next_avail_o    = next_q;

endmodule

// ===== hdl/paged_bump_allocator.sv =====
// Paged bump allocator: one allocate or pool-reset transaction per cycle unless stalled.
//
// Channels: the request channel (in_valid_i / in_stall_o) carries op_i,
// size_bytes_i and align_log2_i; the result channel (out_valid_o /
// out_stall_i) returns status_o, page_index_o, page_offset_o and
// took_page_o. A transaction moves when valid is high and stall is low.
// The page size register is written over cfg_valid_i / cfg_ready_o /
// cfg_data_i; ready is always high, and writes belong in idle periods.
// A request is captured in the input register, decided combinationally by
// the core from that register and registered in the result register,
// which drives out_valid_o.
// Throughput: 1 transaction per cycle unless stalled; the allocator state
// updates as the decision is registered, so back-to-back requests see it.
// Stall: while out_stall_i holds a pending result, the request in the input
// register waits and in_stall_o rises; nothing is dropped.
// Reset: no current page, no pages created, page size 65536 bytes, both
// channels empty.
`timescale 1ns / 1ps

module paged_bump_allocator #(
  parameter int unsigned MaxPages = pba_pkg::DefMaxPages
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [pba_pkg::SizeW-1:0]     size_bytes_i,
  input  logic [pba_pkg::AlignW-1:0]    align_log2_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [pba_pkg::StatusW-1:0]   status_o,
  output logic [pba_pkg::IndexW-1:0]    page_index_o,
  output logic [pba_pkg::SizeW-1:0]     page_offset_o,
  output logic                          took_page_o,
  // page size register
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pba_pkg::SizeW-1:0]     cfg_data_i
);

  localparam int unsigned PW = $clog2(MaxPages + 1);

  logic                        in_valid_q, in_valid_d;
  pba_pkg::pba_item_t          item_q;
  logic                        out_valid_q, out_valid_d;
  pba_pkg::pba_result_t        res_q;
  pba_pkg::pba_result_t        res_d;
  logic [pba_pkg::SizeW-1:0]   page_bytes_q;
  logic                        out_free;
  logic                        fire;
  logic                        accept;
  logic [PW-1:0]               pages_created;
  logic [PW-1:0]               next_avail;

  // Handshake control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  assign in_valid_d  = accept || (in_valid_q && !fire);
  assign out_valid_d = fire || (out_valid_q && !out_free);

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.op         <= op_i;
      item_q.size_bytes <= size_bytes_i;
      item_q.align_log2 <= align_log2_i;
    end
  end

  // Page size register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_bytes_q <= pba_pkg::DefPageBytes;
    end else if (cfg_valid_i && cfg_ready_o) begin
      page_bytes_q <= cfg_data_i;
    end
  end

  // Decision and allocator state
  pba_alloc_core #(
    .MaxPages(MaxPages)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fire_i         (fire),
    .item_i         (item_q),
    .page_bytes_i   (page_bytes_q),
    .result_o       (res_d),
    .pages_created_o(pages_created),
    .next_avail_o   (next_avail)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = res_q.status;
  assign page_index_o  = res_q.page_index;
  assign page_offset_o = res_q.page_offset;
  assign took_page_o   = res_q.took_page;

`ifndef SYNTHESIS
  // Reusable pages always lie below the creation count
  a_pool_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_avail <= pages_created)
    else $error("next available page beyond pages created");

  // Never more pages than the pool allows
  a_pool_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pages_created <= PW'(MaxPages))
    else $error("page count exceeds pool size");

  // A page switch is reported only with a placed or fresh-page result
  a_took_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && took_page_o) |->
      (status_o == pba_pkg::ST_OK || status_o == pba_pkg::ST_NO_FIT))
    else $error("page switch flagged on a failed or reset transaction");

  // A decided request reaches the result register on the next edge
  a_fire_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("decided transaction lost before the result register");
`endif

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the paged bump allocator: predictor, driver and monitor.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned SizeW        = pba_pkg::SizeW;
  localparam int unsigned AlignW       = pba_pkg::AlignW;
  localparam int unsigned IndexW       = pba_pkg::IndexW;
  localparam int unsigned StatusW      = pba_pkg::StatusW;
  localparam int unsigned PoolPages    = pba_pkg::DefMaxPages;
  localparam int unsigned SettleCycles = 4;

  // Receiver stall patterns
  typedef enum logic [2:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_SQUARE,
    STALL_LONG
  } stall_mode_e;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                op;
  logic [SizeW-1:0]    size_bytes;
  logic [AlignW-1:0]   align_log2;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [StatusW-1:0]  status;
  logic [IndexW-1:0]   page_index;
  logic [SizeW-1:0]    page_offset;
  logic                took_page;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [SizeW-1:0]    cfg_data;

  // Requests waiting to be driven and results waiting to be seen
  pba_pkg::pba_item_t   request_backlog[$];
  pba_pkg::pba_result_t expected_replies[$];

  // Predictor copy of the allocator state and page size
  logic             pool_cur_valid  = 1'b0;
  int unsigned      pool_cur_page   = 0;
  logic [SizeW-1:0] pool_fill       = '0;
  int unsigned      pool_created    = 0;
  int unsigned      pool_next_free  = 0;
  logic [SizeW-1:0] pool_page_bytes = pba_pkg::DefPageBytes;

  // Config write requests from the sequencing block
  logic [SizeW-1:0] cfg_value   = '0;
  int unsigned      cfg_asked   = 0;
  int unsigned      cfg_sent    = 0;
  int unsigned      cfg_writes  = 0;

  int unsigned error_count   = 0;
  int unsigned accepted      = 0;
  int unsigned received      = 0;
  int unsigned status_seen[5] = '{0, 0, 0, 0, 0};
  int unsigned took_seen     = 0;

  // Driver pacing
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  // Receiver pacing
  int unsigned stall_cnt  = 0;
  stall_mode_e stall_mode = STALL_NONE;

  paged_bump_allocator #(
    .MaxPages(PoolPages)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .op_i         (op),
    .size_bytes_i (size_bytes),
    .align_log2_i (align_log2),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .status_o     (status),
    .page_index_o (page_index),
    .page_offset_o(page_offset),
    .took_page_o  (took_page),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Exact power-of-two round up in wide arithmetic
  function automatic logic [63:0] round_up_pow2(input logic [63:0] v,
                                                input logic [AlignW-1:0] lg);
    logic [63:0] m;
    m = (64'd1 << lg) - 64'd1;
    return (v + m) & ~m;
  endfunction

  function automatic logic fits_page(input logic [SizeW-1:0] off, input logic [63:0] asz,
                                     input logic [AlignW-1:0] lg);
    return (round_up_pow2({39'd0, off}, lg) + asz) <= {39'd0, pool_page_bytes};
  endfunction

  // Expected reply for one request; advances the predictor state
  task automatic predict_allocation(input pba_pkg::pba_item_t rq,
                                    output pba_pkg::pba_result_t rs);
    logic [63:0] asize;
    logic [63:0] aoff;
    pba_pkg::pba_status_e st;
    st = pba_pkg::ST_OK;
    rs.page_index  = '0;
    rs.page_offset = '0;
    rs.took_page   = 1'b0;
    if (rq.op == pba_pkg::OpReset) begin
      pool_cur_valid = 1'b0;
      pool_fill      = '0;
      pool_next_free = 0;
      st = pba_pkg::ST_RESET;
    end else if (rq.size_bytes > pool_page_bytes) begin
      st = pba_pkg::ST_TOO_BIG;
    end else begin
      asize = round_up_pow2({39'd0, rq.size_bytes}, rq.align_log2);
      // Move to the next page: reuse an available one, else create one
      if (!pool_cur_valid || !fits_page(pool_fill, asize, rq.align_log2)) begin
        if (pool_next_free < pool_created) begin
          pool_cur_page  = pool_next_free;
          pool_next_free = pool_next_free + 1;
        end else if (pool_created < PoolPages) begin
          pool_cur_page  = pool_created;
          pool_created   = pool_created + 1;
          pool_next_free = pool_created;
        end else begin
          st = pba_pkg::ST_EXHAUST;
        end
        if (st == pba_pkg::ST_OK) begin
          pool_cur_valid = 1'b1;
          pool_fill      = '0;
          rs.took_page   = 1'b1;
        end
      end
      if (st == pba_pkg::ST_OK) begin
        rs.page_index = pool_cur_page[IndexW-1:0];
        if (!fits_page(pool_fill, asize, rq.align_log2)) begin
          st = pba_pkg::ST_NO_FIT;
        end else begin
          aoff = round_up_pow2({39'd0, pool_fill}, rq.align_log2);
          rs.page_offset = aoff[SizeW-1:0];
          pool_fill = 25'(aoff + asize);
        end
      end
    end
    rs.status = st;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("%0t ns MISMATCH %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  task automatic queue_request(input logic o, input logic [SizeW-1:0] sz,
                               input logic [AlignW-1:0] lg);
    pba_pkg::pba_item_t rq;
    rq.op         = o;
    rq.size_bytes = sz;
    rq.align_log2 = lg;
    request_backlog.insert(request_backlog.size(), rq);
  endtask

  // Random request shaped around the current page size
  function automatic pba_pkg::pba_item_t make_request(input logic [SizeW-1:0] pb);
    pba_pkg::pba_item_t rq;
    int unsigned pick;
    int unsigned lg_pick;
    int unsigned eighth;
    pick    = $urandom_range(0, 99);
    lg_pick = $urandom_range(0, 99);
    eighth  = (pb / 8 > 0) ? pb / 8 : 1;
    rq.op = pba_pkg::OpAlloc;
    if (lg_pick < 70) begin
      rq.align_log2 = AlignW'($urandom_range(0, 4));
    end else if (lg_pick < 92) begin
      rq.align_log2 = AlignW'($urandom_range(0, $clog2(pb)));
    end else begin
      rq.align_log2 = AlignW'($urandom_range(0, 31));
    end
    if (pick < 3) begin
      rq.op         = pba_pkg::OpReset;
      rq.size_bytes = SizeW'($urandom);
      rq.align_log2 = AlignW'($urandom);
    end else if (pick < 50) begin
      rq.size_bytes = SizeW'($urandom_range(0, eighth));
    end else if (pick < 65) begin
      rq.size_bytes = SizeW'($urandom_range(0, pb));
    end else if (pick < 72) begin
      rq.size_bytes = pb;
    end else if (pick < 78) begin
      rq.size_bytes = pb - SizeW'($urandom_range(1, 3));
    end else if (pick < 84) begin
      rq.size_bytes = pb + SizeW'($urandom_range(1, 4));
    end else begin
      rq.size_bytes = SizeW'($urandom);
    end
    return rq;
  endfunction

  // Request driver: bursts of random length separated by random gaps
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      op         <= pba_pkg::OpAlloc;
      size_bytes <= '0;
      align_log2 <= '0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left--;
      end else if (request_backlog.size() > 0) begin
        pba_pkg::pba_item_t rq;
        rq = request_backlog[0];
        request_backlog.delete(0);
        in_valid   <= 1'b1;
        op         <= rq.op;
        size_bytes <= rq.size_bytes;
        align_log2 <= rq.align_log2;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          case ($urandom_range(0, 5))
            0, 1:    gap_left = 0;
            5:       gap_left = $urandom_range(10, 20);
            default: gap_left = $urandom_range(1, 6);
          endcase
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Request acceptance: predict the reply of each accepted transaction
  always @(posedge clk_i) begin
    if (rst_ni && in_valid && !in_stall) begin
      pba_pkg::pba_item_t   rq;
      pba_pkg::pba_result_t rs;
      rq.op         = op;
      rq.size_bytes = size_bytes;
      rq.align_log2 = align_log2;
      predict_allocation(rq, rs);
      expected_replies.insert(expected_replies.size(), rs);
      accepted++;
    end
  end

  // Page size register writes; the predictor follows each accepted write
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cfg_valid <= 1'b0;
      cfg_data  <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_valid <= 1'b0;
        pool_page_bytes = cfg_data;
        cfg_writes++;
      end else if (!cfg_valid && cfg_sent != cfg_asked) begin
        cfg_valid <= 1'b1;
        cfg_data  <= cfg_value;
        cfg_sent++;
      end
    end
  end

  // Reply monitor and receiver stall pattern
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        received++;
        if (expected_replies.size() == 0) begin
          report_mismatch("reply with nothing expected", {29'd0, status}, 32'd0);
        end else begin
          pba_pkg::pba_result_t want;
          want = expected_replies[0];
          expected_replies.delete(0);
          if (status !== want.status)
            report_mismatch("status", {29'd0, status}, {29'd0, want.status});
          if (page_index !== want.page_index)
            report_mismatch("page_index", {28'd0, page_index}, {28'd0, want.page_index});
          if (page_offset !== want.page_offset)
            report_mismatch("page_offset", {7'd0, page_offset}, {7'd0, want.page_offset});
          if (took_page !== want.took_page)
            report_mismatch("took_page", {31'd0, took_page}, {31'd0, want.took_page});
          if (want.status <= pba_pkg::ST_RESET) status_seen[want.status]++;
          if (want.took_page) took_seen++;
        end
      end
      stall_cnt++;
      if (stall_cnt % 48 == 0) stall_mode = stall_mode_e'($urandom_range(0, 4));
      case (stall_mode)
        STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
        STALL_SQUARE: out_stall <= stall_cnt[2];
        STALL_LONG:   out_stall <= (stall_cnt % 48) < 20;
        default:      out_stall <= 1'b0;
      endcase
    end
  end

  // Wait until every request has been driven and answered, then settle
  task automatic wait_drained();
    do @(negedge clk_i);
    while (request_backlog.size() != 0 || in_valid || expected_replies.size() != 0);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_page_bytes(input logic [SizeW-1:0] v);
    int unsigned writes_at_start;
    writes_at_start = cfg_writes;
    cfg_value       = v;
    cfg_asked++;
    do @(negedge clk_i);
    while (cfg_writes == writes_at_start);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // Sequencing: reset, directed requests, then random phases per page size
  initial begin
    logic [SizeW-1:0] page_plan[6];
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset page size of 64 KiB
    queue_request(pba_pkg::OpAlloc, 25'd0, 5'd0);          // first request takes page 0
    queue_request(pba_pkg::OpAlloc, 25'd100, 5'd4);        // aligned offset and size
    queue_request(pba_pkg::OpAlloc, 25'd65536, 5'd0);      // exact page size, new page
    queue_request(pba_pkg::OpAlloc, 25'd65537, 5'd0);      // one byte too big
    queue_request(pba_pkg::OpAlloc, 25'h1FFFFFF, 5'd31);   // all ones, too big
    queue_request(pba_pkg::OpAlloc, 25'd65535, 5'd17);     // rounds past the page: no fit
    queue_request(pba_pkg::OpAlloc, 25'd0, 5'd31);         // zero size, huge alignment
    queue_request(pba_pkg::OpAlloc, 25'd1, 5'd25);         // alignment beyond 24 bits
    queue_request(pba_pkg::OpReset, 25'h1FFFFFF, 5'd31);   // pool reset, all bits set
    // Whole-page requests: reuse every page, create the rest, then run dry
    for (int i = 0; i <= PoolPages; i++)
      queue_request(pba_pkg::OpAlloc, 25'd65536, 5'd16);
    queue_request(pba_pkg::OpReset, 25'd0, 5'd0);

    page_plan[0] = pba_pkg::DefPageBytes;
    page_plan[1] = 25'd16;
    page_plan[2] = 25'd16777216;
    page_plan[3] = 25'd100;
    page_plan[4] = SizeW'($urandom_range(16, 16777216));
    page_plan[5] = 25'd4096;

    foreach (page_plan[p]) begin
      if (p != 0) begin
        wait_drained();
        write_page_bytes(page_plan[p]);
      end
      for (int i = 0; i < 300; i++)
        request_backlog.insert(request_backlog.size(), make_request(page_plan[p]));
    end

    wait_drained();
    repeat (8) @(negedge clk_i);
    if (expected_replies.size() != 0)
      report_mismatch("replies never returned", 32'(expected_replies.size()), 32'd0);

    $display("Covered %0d requests over %0d page sizes, %0d page switches.",
             accepted, cfg_writes + 1, took_seen);
    $display("Replies: ok %0d, too big %0d, exhausted %0d, no fit %0d, pool reset %0d.",
             status_seen[pba_pkg::ST_OK], status_seen[pba_pkg::ST_TOO_BIG],
             status_seen[pba_pkg::ST_EXHAUST], status_seen[pba_pkg::ST_NO_FIT],
             status_seen[pba_pkg::ST_RESET]);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #6ms;
    $display("Timeout with %0d replies outstanding", expected_replies.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== paged_bump_allocator.f =====
hdl/pba_pkg.sv
hdl/pba_alloc_core.sv
hdl/paged_bump_allocator.sv
test/tb.sv
